>>> hdl/chacha20_keystream_xor_assert.svh
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR - assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_KEYSTREAM_XOR_ASSERT_SVH
`define CHACHA20_KEYSTREAM_XOR_ASSERT_SVH

// same-cycle implication
`define CC20_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("cc20 same-cycle check failed");

// next-cycle implication
`define CC20_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("cc20 next-cycle check failed");

// invariant
`define CC20_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("cc20 invariant failed");

`endif

>>> hdl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants of the ChaCha20 keystream XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

	localparam int WORD_W        = 32;
	localparam int NUM_WORDS     = 16;
	localparam int DOUBLE_ROUNDS = 10;
	localparam int DR_W          = $clog2(DOUBLE_ROUNDS);
	localparam int POS_W         = 7;
	localparam int CFG_W         = 64;
	localparam int IDX_W         = 3;

	typedef logic [WORD_W-1:0]           word_t;
	typedef word_t [NUM_WORDS-1:0]       block_t;

	// "expand 32-byte k"
	localparam word_t SIGMA0 = 32'h6170_7865;
	localparam word_t SIGMA1 = 32'h3320_646e;
	localparam word_t SIGMA2 = 32'h7962_2d32;
	localparam word_t SIGMA3 = 32'h6b20_6574;

	// register indexes
	localparam logic [IDX_W-1:0] REG_KEY_01   = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY_23   = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEY_45   = 3'd2;
	localparam logic [IDX_W-1:0] REG_KEY_67   = 3'd3;
	localparam logic [IDX_W-1:0] REG_NONCE_01 = 3'd4;
	localparam logic [IDX_W-1:0] REG_NONCE_2  = 3'd5;
	localparam logic [IDX_W-1:0] REG_START    = 3'd6;

	typedef struct packed {
		logic start;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

endpackage

`default_nettype wire

>>> hdl/chacha20_keystream_xor.sv
// Result registered, valid in the cycle after the request while the buffered
// block has bytes, else once a new 64-byte block is made. Throughput: 1 byte
// per cycle within a block unless results stall; requests stall while the
// shared half quarter-round unit makes a block, once every 64 bytes.
// Reset (arst_n low, async): registers and counter words zero, block exhausted.
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// XORs a byte stream with ChaCha20 keystream. Key, nonce and start counter
// come from a plain write port; a new block is made whenever the buffered
// one is used up or a message starts.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_xor
	import cc20_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	// request channel
	input  wire logic             data_valid,
	output logic                  data_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic             first_of_message,
	// result channel
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic [7:0]            out_byte,
	output logic                  counter_wrapped
);

	typedef enum logic {
		T_IDLE,
		T_GEN
	} tstate_t;

	// configuration registers
	logic [CFG_W-1:0] key01_q, key23_q, key45_q, key67_q, nonce01_q, start_ctr_q;
	word_t            nonce2_q;

	// running state
	tstate_t          t_state_q;
	word_t            ctr_lo_q;
	word_t            ctr_hi_q;	// nonce word 0 plus counter high word
	logic [POS_W-1:0] pos_q;
	logic [7:0]       data_q;	// byte parked while its block is made
	logic             start_q;
	logic             valid_q;
	logic [7:0]       out_byte_q;
	logic             wrapped_q;

	core_ctl_t core_ctl;
	core_sts_t core_sts;
	block_t    init_blk;
	block_t    ks_blk;

	logic  accept;
	logic  need_gen;
	word_t ks_word;
	logic  [7:0] ks_byte;
	word_t ctr_lo_inc;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q     <= '0;
			key23_q     <= '0;
			key45_q     <= '0;
			key67_q     <= '0;
			nonce01_q   <= '0;
			nonce2_q    <= '0;
			start_ctr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_01:   key01_q     <= cfg_data;
				REG_KEY_23:   key23_q     <= cfg_data;
				REG_KEY_45:   key45_q     <= cfg_data;
				REG_KEY_67:   key67_q     <= cfg_data;
				REG_NONCE_01: nonce01_q   <= cfg_data;
				REG_NONCE_2:  nonce2_q    <= cfg_data[WORD_W-1:0];
				REG_START:    start_ctr_q <= cfg_data;
				default: begin
					// unused index: write dropped
				end
			endcase
		end
	end

	// ----------------------------------------------------------- input state
	// Words 12/13 come from the running counter; word 13 already carries
	// nonce word 0, which is folded in only at message start.
	always_comb begin
		init_blk[0]  = SIGMA0;
		init_blk[1]  = SIGMA1;
		init_blk[2]  = SIGMA2;
		init_blk[3]  = SIGMA3;
		init_blk[4]  = key01_q[31:0];
		init_blk[5]  = key01_q[63:32];
		init_blk[6]  = key23_q[31:0];
		init_blk[7]  = key23_q[63:32];
		init_blk[8]  = key45_q[31:0];
		init_blk[9]  = key45_q[63:32];
		init_blk[10] = key67_q[31:0];
		init_blk[11] = key67_q[63:32];
		init_blk[12] = ctr_lo_q;
		init_blk[13] = ctr_hi_q;
		init_blk[14] = nonce01_q[63:32];
		init_blk[15] = nonce2_q;
	end

	assign core_ctl.start = start_q;

	cc20_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.init   (init_blk),
		.sts    (core_sts),
		.ks     (ks_blk)
	);

	// ------------------------------------------------------------ handshake
	// A request is taken only in idle and only when the result register is
	// empty or drains at this edge.
	assign data_stall = (t_state_q != T_IDLE) || (valid_q && result_stall);
	assign accept     = data_valid && !data_stall;

	// position 64 and above means the buffered block is used up
	assign need_gen   = first_of_message || pos_q[POS_W-1];

	assign ks_word    = ks_blk[pos_q[5:2]];
	assign ks_byte    = 8'(ks_word >> {pos_q[1:0], 3'b000});
	assign ctr_lo_inc = ctr_lo_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_state_q  <= T_IDLE;
			ctr_lo_q   <= '0;
			ctr_hi_q   <= '0;
			pos_q      <= POS_W'(64);
			data_q     <= '0;
			start_q    <= 1'b0;
			valid_q    <= 1'b0;
			out_byte_q <= '0;
			wrapped_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (valid_q && !result_stall) begin
				valid_q <= 1'b0;
			end
			case (t_state_q)
				T_IDLE: begin
					if (accept) begin
						if (first_of_message) begin
							ctr_lo_q <= start_ctr_q[31:0];
							ctr_hi_q <= nonce01_q[31:0] + start_ctr_q[63:32];
						end
						if (need_gen) begin
							// park the byte, core loads on the next edge
							data_q    <= data_byte;
							start_q   <= 1'b1;
							t_state_q <= T_GEN;
						end else begin
							out_byte_q <= data_byte ^ ks_byte;
							wrapped_q  <= 1'b0;
							valid_q    <= 1'b1;
							pos_q      <= pos_q + POS_W'(1);
						end
					end
				end
				T_GEN: begin
					if (core_sts.done) begin
						// counter advance after the block; flag a wrap of word 13
						ctr_lo_q <= ctr_lo_inc;
						if (ctr_lo_inc == '0) begin
							ctr_hi_q <= ctr_hi_q + 32'd1;
						end
						wrapped_q  <= (ctr_lo_q == '1) && (ctr_hi_q == '1);
						out_byte_q <= data_q ^ ks_blk[0][7:0];
						valid_q    <= 1'b1;
						pos_q      <= POS_W'(1);
						t_state_q  <= T_IDLE;
					end
				end
				default: begin
					t_state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign result_valid    = valid_q;
	assign out_byte        = out_byte_q;
	assign counter_wrapped = wrapped_q;

	// ----------------------------------------------------------- assertions
`include "chacha20_keystream_xor_assert.svh"

	// a finished block is only ever expected while a request waits for it
	`CC20_ASSERT_IMPL(a_done_in_gen, clk, arst_n, core_sts.done, t_state_q == T_GEN)
	// no request may slip in while the core is making a block
	`CC20_ASSERT_IMPL(a_busy_stalls, clk, arst_n, core_sts.busy, data_stall)
	// a request that needs a block kicks the core on the next cycle
	`CC20_ASSERT_NEXT(a_gen_starts, clk, arst_n, accept && need_gen, start_q)
	// byte position never runs past the exhausted mark
	`CC20_ASSERT_ALWAYS(a_pos_range, clk, arst_n, pos_q <= POS_W'(64))

endmodule

`default_nettype wire

>>> hdl/cc20_qr_half.sv
// ----------------------------------------------------------------------------
// cc20_qr_half
// Half of a ChaCha20 quarter round: two add-xor-rotate lines.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_qr_half
	import cc20_pkg::*;
(
	input  wire word_t a,
	input  wire word_t b,
	input  wire word_t c,
	input  wire word_t d,
	input  wire logic  second,	// 0: rotates 16/12, 1: rotates 8/7
	output word_t      a_o,
	output word_t      b_o,
	output word_t      c_o,
	output word_t      d_o
);

	word_t a1, dx, d1, c1, bx, b1;

	always_comb begin
		a1 = a + b;
		dx = d ^ a1;
		if (second) begin
			d1 = {dx[23:0], dx[31:24]};
		end else begin
			d1 = {dx[15:0], dx[31:16]};
		end
		c1 = c + d1;
		bx = b ^ c1;
		if (second) begin
			b1 = {bx[24:0], bx[31:25]};
		end else begin
			b1 = {bx[19:0], bx[31:20]};
		end
	end

	assign a_o = a1;
	assign b_o = b1;
	assign c_o = c1;
	assign d_o = d1;

endmodule

`default_nettype wire

>>> hdl/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Block function: state array, one shared half quarter-round unit, sequencer.
// The unit always works on column 0; rows are rotated to bring the next
// column or the diagonals into place.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_core
	import cc20_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire core_ctl_t ctl,
	input  wire block_t    init,
	output core_sts_t      sts,
	output block_t         ks
);

	typedef enum logic [2:0] {
		C_IDLE,
		C_COL,
		C_DIAG,
		C_UNDIAG,
		C_FINAL
	} cstate_t;

	cstate_t          state_q;
	logic             half_q;
	logic [1:0]       col_q;
	logic             diag_q;
	logic [DR_W-1:0]  dr_q;
	logic             done_q;

	block_t w_q, w_next;
	word_t  qa, qb, qc, qd;

	cc20_qr_half u_qr (
		.a      (w_q[0]),
		.b      (w_q[4]),
		.c      (w_q[8]),
		.d      (w_q[12]),
		.second (half_q),
		.a_o    (qa),
		.b_o    (qb),
		.c_o    (qc),
		.d_o    (qd)
	);

	always_comb begin
		block_t upd;
		upd    = w_q;
		w_next = w_q;
		case (state_q)
			C_IDLE: begin
				if (ctl.start) begin
					w_next = init;
				end
			end
			C_COL: begin
				upd[0]  = qa;
				upd[4]  = qb;
				upd[8]  = qc;
				upd[12] = qd;
				w_next  = upd;
				// column finished: move next column into place
				if (half_q) begin
					for (int r = 0; r < 4; r++) begin
						for (int j = 0; j < 4; j++) begin
							w_next[4*r+j] = upd[4*r+((j+1)%4)];
						end
					end
				end
			end
			C_DIAG: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						w_next[4*r+j] = w_q[4*r+((j+r)%4)];
					end
				end
			end
			C_UNDIAG: begin
				for (int r = 0; r < 4; r++) begin
					for (int j = 0; j < 4; j++) begin
						w_next[4*r+j] = w_q[4*r+((j+4-r)%4)];
					end
				end
			end
			C_FINAL: begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					w_next[i] = w_q[i] + init[i];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		w_q <= w_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			half_q  <= 1'b0;
			col_q   <= 2'd0;
			diag_q  <= 1'b0;
			dr_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (ctl.start) begin
						state_q <= C_COL;
						half_q  <= 1'b0;
						col_q   <= 2'd0;
						diag_q  <= 1'b0;
						dr_q    <= '0;
					end
				end
				C_COL: begin
					half_q <= ~half_q;
					if (half_q) begin
						col_q <= col_q + 2'd1;
						if (col_q == 2'd3) begin
							state_q <= diag_q ? C_UNDIAG : C_DIAG;
						end
					end
				end
				C_DIAG: begin
					diag_q  <= 1'b1;
					state_q <= C_COL;
				end
				C_UNDIAG: begin
					diag_q <= 1'b0;
					if (dr_q == DR_W'(DOUBLE_ROUNDS - 1)) begin
						state_q <= C_FINAL;
					end else begin
						dr_q    <= dr_q + DR_W'(1);
						state_q <= C_COL;
					end
				end
				C_FINAL: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.done = done_q;
	assign ks       = w_q;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ChaCha20 keystream XOR block. Each accepted
// request is run through a behavioral ChaCha20 predictor. The expected byte
// and counter-wrap flag are queued and matched in order against the results.
// Key, nonce and counter settings change between phases while the block is
// idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cc20_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 3_000_000;
	localparam int unsigned DRAIN_LIMIT   = 20_000;
	localparam int unsigned SETTLE_CYCLES = 200;   // a little over one block build
	localparam int unsigned PHASE_ITEMS   = 250;
	localparam int unsigned MAX_REPORTS   = 100;

	// index with no register behind it; writes to it must be dropped
	localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef enum int {SET_ZERO, SET_ONES, SET_RANDOM, SET_NEAR_WRAP} setting_kind_t;

	// ------------------------------------------------------------------------
	// Keystream predictor and result checker
	// ------------------------------------------------------------------------
	class keystream_scoreboard;
		typedef struct packed {
			logic [7:0] text;
			logic       wrapped;
		} expected_t;

		// register mirror
		logic [CFG_W-1:0] key_reg[4];
		logic [CFG_W-1:0] nonce_01;
		word_t            nonce_2;
		logic [CFG_W-1:0] start_ctr;

		// running cipher state
		word_t       ctr_low;
		word_t       ctr_high;     // nonce word 0 plus counter high half
		word_t       ks_block[NUM_WORDS];
		word_t       mix[NUM_WORDS];
		int unsigned byte_pos;

		expected_t   expected_q[$];
		int unsigned mismatches;

		function new();
			foreach (key_reg[i])
				key_reg[i] = '0;
			nonce_01   = '0;
			nonce_2    = '0;
			start_ctr  = '0;
			ctr_low    = '0;
			ctr_high   = '0;
			foreach (ks_block[i])
				ks_block[i] = '0;
			byte_pos   = 64;
			mismatches = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_KEY_01:   key_reg[0] = value;
				REG_KEY_23:   key_reg[1] = value;
				REG_KEY_45:   key_reg[2] = value;
				REG_KEY_67:   key_reg[3] = value;
				REG_NONCE_01: nonce_01   = value;
				REG_NONCE_2:  nonce_2    = value[WORD_W-1:0];
				REG_START:    start_ctr  = value;
				default: ;
			endcase
		endfunction

		function word_t rotl(word_t v, int unsigned s);
			return (v << s) | (v >> (WORD_W - s));
		endfunction

		function void qround(int a, int b, int c, int d);
			mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
			mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
			mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
			mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
		endfunction

		// builds the next 64-byte block, advances the counter, flags a wrap of word 13
		function bit make_block();
			word_t init[NUM_WORDS];
			init[0] = SIGMA0;
			init[1] = SIGMA1;
			init[2] = SIGMA2;
			init[3] = SIGMA3;
			for (int k = 0; k < 4; k++) begin
				init[4 + 2 * k] = key_reg[k][31:0];
				init[5 + 2 * k] = key_reg[k][63:32];
			end
			init[12] = ctr_low;
			init[13] = ctr_high;
			init[14] = nonce_01[63:32];
			init[15] = nonce_2;
			mix = init;
			for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
				qround(0, 4, 8, 12);
				qround(1, 5, 9, 13);
				qround(2, 6, 10, 14);
				qround(3, 7, 11, 15);
				qround(0, 5, 10, 15);
				qround(1, 6, 11, 12);
				qround(2, 7, 8, 13);
				qround(3, 4, 9, 14);
			end
			foreach (ks_block[i])
				ks_block[i] = mix[i] + init[i];
			ctr_low++;
			if (ctr_low == '0) begin
				ctr_high++;
				return ctr_high == '0;
			end
			return 1'b0;
		endfunction

		function void note_request(logic [7:0] data, logic first);
			expected_t  e;
			logic [7:0] ks;
			e.wrapped = 1'b0;
			if (first) begin
				ctr_low  = start_ctr[31:0];
				ctr_high = nonce_01[31:0] + start_ctr[63:32];
				byte_pos = 64;
			end
			if (byte_pos >= 64) begin
				e.wrapped = make_block();
				byte_pos  = 0;
			end
			ks       = 8'(ks_block[(byte_pos >> 2) % NUM_WORDS] >> (8 * (byte_pos % 4)));
			byte_pos = (byte_pos + 1) & 'h7f;
			e.text   = data ^ ks;
			expected_q.push_back(e);
		endfunction

		task check_result(logic [7:0] text, logic wrapped);
			expected_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result %02h arrived with no request waiting", text));
				return;
			end
			e = expected_q.pop_front();
			if (text !== e.text)
				report($sformatf("out_byte %02h, expected %02h", text, e.text));
			if (wrapped !== e.wrapped)
				report($sformatf("counter_wrapped %b, expected %b", wrapped, e.wrapped));
		endtask

		task report(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block hookup; every input known from time zero
	// ------------------------------------------------------------------------
	logic             clk              = 1'b0;
	logic             arst_n           = 1'b0;
	logic             cfg_we           = 1'b0;
	logic [IDX_W-1:0] cfg_index        = '0;
	logic [CFG_W-1:0] cfg_data         = '0;
	logic             data_valid       = 1'b0;
	logic             data_stall;
	logic [7:0]       data_byte        = '0;
	logic             first_of_message = 1'b0;
	logic             result_valid;
	logic             result_stall     = 1'b0;
	logic [7:0]       out_byte;
	logic             counter_wrapped;

	int unsigned idle_pct    = 0;   // sender gap odds per cycle
	int unsigned stall_pct   = 0;   // receiver stall odds per cycle
	int unsigned cycle_count = 0;

	keystream_scoreboard sb = new();

	chacha20_keystream_xor dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.data_valid       (data_valid),
		.data_stall       (data_stall),
		.data_byte        (data_byte),
		.first_of_message (first_of_message),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.out_byte         (out_byte),
		.counter_wrapped  (counter_wrapped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver back-pressure, changed only on the falling edge
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Both handshakes sampled on the rising edge. The request is noted first so
	// that the expectation queue is up to date before any result is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (data_valid && !data_stall)
				sb.note_request(data_byte, first_of_message);
			if (result_valid && !result_stall)
				sb.check_result(out_byte, counter_wrapped);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers; each task starts and ends just after a falling edge
	// ------------------------------------------------------------------------
	function automatic logic [CFG_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	// Writes every register (or a random subset when partial) and, half the time, a
	// stray write to the unmapped index, which the block has to drop.
	task automatic load_settings(input logic [CFG_W-1:0] key01, input logic [CFG_W-1:0] key23,
			input logic [CFG_W-1:0] key45, input logic [CFG_W-1:0] key67,
			input logic [CFG_W-1:0] nonce01, input logic [CFG_W-1:0] nonce2,
			input logic [CFG_W-1:0] start, input bit partial);
		logic [CFG_W-1:0] vals[REG_START + 1];
		vals[REG_KEY_01]   = key01;
		vals[REG_KEY_23]   = key23;
		vals[REG_KEY_45]   = key45;
		vals[REG_KEY_67]   = key67;
		vals[REG_NONCE_01] = nonce01;
		vals[REG_NONCE_2]  = nonce2;
		vals[REG_START]    = start;
		for (int i = 0; i <= REG_START; i++) begin
			if (!partial || $urandom_range(9) < 7)
				write_reg(IDX_W'(i), vals[i]);
		end
		if ($urandom_range(1))
			write_reg(REG_UNMAPPED, rand64());
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings(input setting_kind_t kind, input bit partial);
		logic [CFG_W-1:0] k0, k1, k2, k3, n01, n2, start;
		word_t            n0;
		k0    = rand64();
		k1    = rand64();
		k2    = rand64();
		k3    = rand64();
		n01   = rand64();
		n2    = rand64();   // upper half is junk the block must ignore
		start = rand64();
		case (kind)
			SET_ZERO: begin
				{k0, k1, k2, k3, n01, n2, start} = '0;
			end
			SET_ONES: begin
				{k0, k1, k2, k3, n01, n2, start} = '1;
			end
			SET_NEAR_WRAP: begin
				// low half a few blocks short of wrapping; high half often set so
				// that nonce word 0 plus it is all ones, making word 13 wrap too
				n0          = $urandom_range(1) ? '0 : word_t'($urandom);
				n01[31:0]   = n0;
				start[63:32] = $urandom_range(1) ? 32'hFFFF_FFFF - n0 : word_t'($urandom);
				start[31:0]  = 32'hFFFF_FFFF - $urandom_range(3);
			end
			default: ;
		endcase
		load_settings(k0, k1, k2, k3, n01, n2, start, partial);
	endtask

	// One request; valid stays up across back-to-back requests and drops only
	// when a gap is inserted.
	task automatic send_byte(input logic [7:0] value, input logic first);
		if ($urandom_range(99) < idle_pct) begin
			data_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		data_valid       <= 1'b1;
		data_byte        <= value;
		first_of_message <= first;
		do
			@(posedge clk);
		while (data_stall);
		@(negedge clk);
	endtask

	// Lowers valid, then waits for every expected result and a block build's
	// worth of extra cycles so no late result goes unseen.
	task automatic drain();
		int unsigned n = 0;
		data_valid <= 1'b0;
		while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned len;
		int unsigned pick;
		int unsigned sent;
		bit          opening;
		bit          carry_on;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// No message start yet: counter words stay at zero, so word 13 leaves
		// out nonce word 0 even though it is already programmed.
		load_settings(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
			rand64(), 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		// message start mid-block, then a second start right behind it
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h81, 1'b0);
		drain();

		// full counter at all ones with nonce word 0 zero: wrap flag on first byte
		load_settings(rand64(), rand64(), rand64(), rand64(), {$urandom, 32'h0},
			rand64(), '1, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		drain();

		// nonce word 0 plus the high half overflows to zero on load
		load_settings(rand64(), rand64(), rand64(), rand64(), {$urandom, 32'hFFFF_FFFF},
			rand64(), 64'h0000_0001_FFFF_FFFE, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'hC3, 1'b0);
		drain();

		// all-zero and all-ones settings; the latter wraps the low word only
		load_settings('0, '0, '0, '0, '0, '0, '0, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		drain();
		load_settings('1, '1, '1, '1, '1, '1, '1, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		drain();

		// Random phases: no idling, sender gaps, receiver stalls, then both.
		// Each idling mode runs under two settings, covering every kind.
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 65; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			for (int ph = 0; ph < 2; ph++) begin
				random_settings(setting_kind_t'((mode * 2 + ph) % 4), ph == 1);
				sent    = 0;
				opening = 1'b1;
				while (sent < PHASE_ITEMS) begin
					if ($urandom_range(99) < 85) begin
						// well-formed message; some span several blocks
						pick = $urandom_range(99);
						if (pick < 5)
							len = 1;
						else if (pick < 75)
							len = $urandom_range(70, 1);
						else
							len = $urandom_range(200, 65);
						// now and then the first message picks up where the
						// previous phase left off, under the new key
						carry_on = opening && ($urandom_range(9) == 0);
						for (int i = 0; i < len; i++)
							send_byte(8'($urandom), i == 0 && !carry_on);
					end else begin
						// noise: message starts at random
						len = $urandom_range(10, 1);
						for (int i = 0; i < len; i++)
							send_byte(8'($urandom), 1'($urandom_range(1)));
					end
					opening = 1'b0;
					sent += len;
				end
				drain();
			end
		end

		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/cc20_pkg.sv
hdl/cc20_qr_half.sv
hdl/cc20_core.sv
hdl/chacha20_keystream_xor.sv
tb/tb_top.sv
